// File: hw/rtl/http_over_tcp_frame_classifier_unit_assert.svh
// Assertion macros for the HTTP-over-TCP frame classifier.
// Define ASSERT_OFF to compile all checks away.
`ifndef HTTP_OVER_TCP_FRAME_CLASSIFIER_UNIT_ASSERT_SVH
`define HTTP_OVER_TCP_FRAME_CLASSIFIER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define HOTC_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("hotc assertion failed");
// Check a property on every clock edge, reset included.
`define HOTC_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) (prop)) \
    else $error("hotc assertion failed");
`else
`define HOTC_ASSERT(lbl, ck, rn, prop)
`define HOTC_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

// File: hw/rtl/hotc_pkg.sv
// ---------------------------------------------------------------------------
// hotc_pkg
// Shared types and protocol constants of the HTTP-over-TCP frame classifier.
// ---------------------------------------------------------------------------
package hotc_pkg;

  typedef logic [7:0] byte_t;

  localparam int CAPTURE_BYTES_DEF = 64;
  localparam int ETH_HEADER_BYTES  = 14;
  localparam int HEAD_KEEP         = 13;
  localparam int WIN_BYTES         = 6;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [16:0] MIN_PAYLOAD    = 17'd7;

  localparam logic [23:0] M_GET    = "GET";
  localparam logic [31:0] M_POST   = "POST";
  localparam logic [23:0] M_PUT    = "PUT";
  localparam logic [47:0] M_DELETE = "DELETE";
  localparam logic [31:0] M_HTTP   = "HTTP";

endpackage

// File: hw/rtl/hotc_capture_ram.sv
// ---------------------------------------------------------------------------
// hotc_capture_ram
// Payload capture store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module hotc_capture_ram
  import hotc_pkg::*;
#(
  parameter int DEPTH = CAPTURE_BYTES_DEF,
  parameter int AW    = $clog2(CAPTURE_BYTES_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  byte_t         wdata,
  input  logic [AW-1:0] raddr,
  output byte_t         rdata
);

  byte_t mem [DEPTH];

  // write the captured byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/http_over_tcp_frame_classifier_unit.sv
// ---------------------------------------------------------------------------
// http_over_tcp_frame_classifier_unit
// Filters untagged Ethernet frames down to IPv4/TCP segments carrying HTTP.
// ---------------------------------------------------------------------------
// Frame bytes enter one per cycle while in S_RX; header fields are picked off
// by position and payload bytes land in a CAPTURE_BYTES-deep capture RAM.
// After the last beat of a frame the block takes the filter decision in
// S_CHK, during which no input is taken. A kept frame then drains
// CAPTURE_BYTES result beats, each through a capture RAM read (S_RD), an
// output register load (S_LD) and the output handshake (S_WAIT), which
// waits out any backpressure; input is held off for the whole drain.
// Header bytes that never arrive read as zero.
module http_over_tcp_frame_classifier_unit
  import hotc_pkg::*;
#(
  parameter int CAPTURE_BYTES = CAPTURE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // frame_byte[7:0], interface_index[39:8]
  input  logic         in_tlast,
  input  logic [2:0]   in_tuser,   // packet_type[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // src_ip[31:0], dst_ip[63:32], src_port[79:64], dst_port[95:80],
  // pay_len[111:96], interface_index_out[143:112],
  // frame_length[159:144], capture_index[165:160], capture_byte[173:166]
  output logic [175:0] out_tdata,
  output logic         out_tlast,  // capture_last
  output logic [2:0]   out_tuser   // packet_type_out[2:0]
);

  `include "http_over_tcp_frame_classifier_unit_assert.svh"

  localparam int AW = $clog2(CAPTURE_BYTES);
  localparam logic [AW-1:0] LAST_I = AW'(CAPTURE_BYTES - 1);

  typedef enum logic [2:0] {S_RX, S_CHK, S_RD, S_LD, S_WAIT} state_t;

  state_t        state_r;
  logic [15:0]   pos_r;
  logic [15:0]   etype_r;
  logic [5:0]    ihb_r;
  logic [13:0]   frag_r;
  logic [7:0]    proto_r;
  logic [15:0]   tot_r;
  logic [5:0]    thb_r;
  logic [63:0]   addr_r;
  logic [2:0]    ptype_r;
  logic [31:0]   ifidx_r;
  byte_t         head_r [HEAD_KEEP];
  byte_t         win_r  [WIN_BYTES];
  logic [AW-1:0] drain_i_r;

  logic          out_valid_r;
  logic [175:0]  out_data_r;
  logic          out_last_r;
  logic [2:0]    out_user_r;

  byte_t         b;
  logic [16:0]   p17, t17, ps17, d17, len17, q17, pl17;
  logic          in_acc, head_hit, cap_hit;
  logic [3:0]    head_idx, qh_idx;
  byte_t         ram_rdata;
  byte_t         cap_byte;
  byte_t         w [WIN_BYTES];
  logic          method_ok, keep;
  logic [15:0]   pos_nxt;

  assign b        = in_tdata[7:0];
  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_RX);
  assign p17      = {1'b0, pos_r};
  assign t17      = 17'(ETH_HEADER_BYTES) + {11'd0, ihb_r};
  assign ps17     = t17 + {11'd0, thb_r};
  assign d17      = p17 - ps17;
  assign len17    = {1'b0, pos_r};
  assign pos_nxt  = (pos_r != 16'hFFFF) ? pos_r + 16'd1 : pos_r;

  // locate TCP head bytes and capture bytes
  assign head_hit = (ihb_r >= 6'd20) && (p17 > 17'(ETH_HEADER_BYTES)) &&
                    (p17 >= t17) && (p17 < t17 + 17'(HEAD_KEEP));
  assign head_idx = 4'(p17 - t17);
  assign cap_hit  = (ihb_r >= 6'd20) && (p17 > 17'(ETH_HEADER_BYTES)) &&
                    (p17 >= t17 + 17'(HEAD_KEEP)) && (p17 >= ps17) &&
                    (d17 < 17'(CAPTURE_BYTES));

  hotc_capture_ram #(
    .DEPTH (CAPTURE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (in_acc && cap_hit),
    .waddr (d17[AW-1:0]),
    .wdata (b),
    .raddr (drain_i_r),
    .rdata (ram_rdata)
  );

  // payload window for the method match
  always_comb begin
    logic [16:0] qw;
    for (int i = 0; i < WIN_BYTES; i++) begin
      qw = ps17 + 17'(i);
      if (qw >= len17) begin
        w[i] = '0;
      end else if (qw < t17 + 17'(HEAD_KEEP)) begin
        w[i] = head_r[4'(qw - t17)];
      end else begin
        w[i] = win_r[i];
      end
    end
  end

  assign method_ok = ({w[0], w[1], w[2]} == M_GET) ||
                     ({w[0], w[1], w[2], w[3]} == M_POST) ||
                     ({w[0], w[1], w[2]} == M_PUT) ||
                     ({w[0], w[1], w[2], w[3], w[4], w[5]} == M_DELETE) ||
                     ({w[0], w[1], w[2], w[3]} == M_HTTP);

  // filter decision over the finished header registers
  assign pl17 = {1'b0, tot_r} - {11'd0, ihb_r} - {11'd0, thb_r};
  assign keep = (etype_r == ETHERTYPE_IPV4) && (frag_r == '0) &&
                (ihb_r >= 6'd20) && (proto_r == PROTO_TCP) &&
                !pl17[16] && (pl17 >= MIN_PAYLOAD) && method_ok;

  // captured byte for the current drain slot
  assign q17    = ps17 + 17'(drain_i_r);
  assign qh_idx = 4'(q17 - t17);
  always_comb begin
    if (q17 >= len17) begin
      cap_byte = '0;
    end else if (q17 < t17 + 17'(HEAD_KEEP)) begin
      cap_byte = head_r[qh_idx];
    end else begin
      cap_byte = ram_rdata;
    end
  end

  // state, frame header registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RX;
      pos_r       <= '0;
      etype_r     <= '0;
      ihb_r       <= '0;
      frag_r      <= '0;
      proto_r     <= '0;
      tot_r       <= '0;
      thb_r       <= '0;
      addr_r      <= '0;
      ptype_r     <= '0;
      ifidx_r     <= '0;
      drain_i_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HEAD_KEEP; i++) head_r[i] <= '0;
      for (int i = 0; i < WIN_BYTES; i++) win_r[i] <= '0;
    end else begin
      unique case (state_r)
        S_RX: begin
          if (in_acc) begin
            if (pos_r == 16'd0) begin
              ptype_r <= in_tuser;
              ifidx_r <= in_tdata[39:8];
            end
            if (pos_r == 16'd12) etype_r[15:8] <= b;
            if (pos_r == 16'd13) etype_r[7:0] <= b;
            if (pos_r == 16'(ETH_HEADER_BYTES)) ihb_r <= {b[3:0], 2'b00};
            if (pos_r == 16'(ETH_HEADER_BYTES + 2)) tot_r[15:8] <= b;
            if (pos_r == 16'(ETH_HEADER_BYTES + 3)) tot_r[7:0] <= b;
            if (pos_r == 16'(ETH_HEADER_BYTES + 6)) frag_r[13:8] <= b[5:0];
            if (pos_r == 16'(ETH_HEADER_BYTES + 7)) frag_r[7:0] <= b;
            if (pos_r == 16'(ETH_HEADER_BYTES + 9)) proto_r <= b;
            if (pos_r >= 16'(ETH_HEADER_BYTES + 12) && pos_r < 16'(ETH_HEADER_BYTES + 20)) begin
              addr_r <= {addr_r[55:0], b};
            end
            if (head_hit) begin
              head_r[head_idx] <= b;
              if (head_idx == 4'(HEAD_KEEP - 1)) thb_r <= {b[7:4], 2'b00};
            end
            if (cap_hit && d17 < 17'(WIN_BYTES)) win_r[3'(d17)] <= b;
            pos_r <= pos_nxt;
            if (in_tlast) state_r <= S_CHK;
          end
        end
        S_CHK: begin
          drain_i_r <= '0;
          state_r   <= keep ? S_RD : S_RX;
          if (!keep) begin
            pos_r   <= '0;
            etype_r <= '0;
            ihb_r   <= '0;
            frag_r  <= '0;
            proto_r <= '0;
            tot_r   <= '0;
            thb_r   <= '0;
            addr_r  <= '0;
            ptype_r <= '0;
            ifidx_r <= '0;
            for (int i = 0; i < HEAD_KEEP; i++) head_r[i] <= '0;
            for (int i = 0; i < WIN_BYTES; i++) win_r[i] <= '0;
          end
        end
        S_RD: begin
          state_r <= S_LD;
        end
        S_LD: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (drain_i_r == LAST_I);
          out_user_r  <= ptype_r;
          out_data_r  <= {2'b00, cap_byte, 6'(drain_i_r), pos_r, ifidx_r,
                          pl17[15:0], head_r[2], head_r[3], head_r[0], head_r[1],
                          addr_r[31:0], addr_r[63:32]};
          state_r     <= S_WAIT;
        end
        S_WAIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_RX;
              pos_r   <= '0;
              etype_r <= '0;
              ihb_r   <= '0;
              frag_r  <= '0;
              proto_r <= '0;
              tot_r   <= '0;
              thb_r   <= '0;
              addr_r  <= '0;
              ptype_r <= '0;
              ifidx_r <= '0;
              for (int i = 0; i < HEAD_KEEP; i++) head_r[i] <= '0;
              for (int i = 0; i < WIN_BYTES; i++) win_r[i] <= '0;
            end else begin
              drain_i_r <= drain_i_r + AW'(1);
              state_r   <= S_RD;
            end
          end
        end
        default: begin
          state_r <= S_RX;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // drain and receive never overlap
  `HOTC_ASSERT(a_no_rx_in_drain, clk, rst_n, !(out_tvalid && in_tready))
  // the last beat of a run is the final capture slot
  `HOTC_ASSERT(a_last_slot, clk, rst_n, (out_tvalid && out_tlast) |-> (drain_i_r == LAST_I))
  // an intermediate beat taken moves on to the next RAM read
  `HOTC_ASSERT(a_next_read, clk, rst_n, (out_tvalid && out_tready && !out_tlast) |=> (state_r == S_RD))
  // frame state is cleared once a run completes
  `HOTC_ASSERT(a_clear_after, clk, rst_n, (out_tvalid && out_tready && out_tlast) |=> (pos_r == 16'd0))

endmodule
